### hw/rtl/btfifo_pkg.sv
// Shared types and constants for the byte- and time-bounded descriptor FIFO.
// No dependencies; imported by the controller, datapath and top level.
package btfifo_pkg;

   // Field widths fixed by the interface
   localparam int LEN_W   = 32;
   localparam int STAMP_W = 64;
   localparam int SPAN_W  = 48;
   localparam int BYTES_W = 40;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 48;

   // Operations
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_STORED  = 2'd0;
   localparam logic [1:0] STATUS_LARGE   = 2'd1;
   localparam logic [1:0] STATUS_EARLY   = 2'd2;
   localparam logic [1:0] STATUS_CLEARED = 2'd3;

   // Register indexes
   localparam logic CSR_MAX_BYTES = 1'b0;
   localparam logic CSR_MAX_SPAN  = 1'b1;

   localparam logic [LEN_W-1:0]   MAX_BYTES_RESET = 32'd1048576;
   localparam logic [SPAN_W-1:0]  MAX_SPAN_RESET  = '0;
   localparam logic [BYTES_W-1:0] BYTES_SAT       = '1;

   // Input beat
   typedef struct packed {
      logic                      operation;
      logic [LEN_W-1:0]          msg_length;
      logic signed [STAMP_W-1:0] timestamp;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] evicted_count;
      logic [COUNT_W-1:0] entry_count;
      logic [BYTES_W-1:0] bytes_held;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       latch;
      logic       do_clear;
      logic       evict;
      logic       append;
      logic       status_we;
      logic [1:0] status;
      logic       load_rsp;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_clear;
      logic too_large;
      logic byte_over;
      logic empty;
      logic full;
      logic span_on;
      logic ts_before;
      logic out_of_span;
      logic out_free;
   } sts_type;

endpackage

### hw/rtl/btfifo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btfifo_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port (returns old data on a same-address write)
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/btfifo_dp.sv
// Datapath: descriptor ring, head pointer, counts, byte total, config and result register.
// Depends on btfifo_pkg and btfifo_ram.
module btfifo_dp #(
   parameter int ENTRY_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  btfifo_pkg::req_type          req_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [btfifo_pkg::CSR_W-1:0] csr_wdata,
   input  btfifo_pkg::cmd_type          cmd,
   output btfifo_pkg::sts_type          sts,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output btfifo_pkg::rsp_type          rsp_data
);
   import btfifo_pkg::*;

   localparam int AW = $clog2(ENTRY_DEPTH);
   localparam int CW = $clog2(ENTRY_DEPTH + 1);
   localparam int RW = LEN_W + STAMP_W;

   logic                      op_ff;
   logic [LEN_W-1:0]          len_ff;
   logic signed [STAMP_W-1:0] ts_ff;
   logic [LEN_W-1:0]          max_bytes_ff, max_bytes_in;
   logic [SPAN_W-1:0]         max_span_ff, max_span_in;
   logic [AW-1:0]             oldest_ff, oldest_in;
   logic [CW-1:0]             entries_ff, entries_in;
   logic [BYTES_W-1:0]        bytes_ff, bytes_in;
   logic [CW-1:0]             evicted_ff, evicted_in;
   logic [1:0]                status_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff;

   logic [RW-1:0]             rd_data;
   logic [LEN_W-1:0]          head_len;
   logic [STAMP_W-1:0]        head_ts;
   logic [BYTES_W:0]          bytes_sum;
   logic [STAMP_W:0]          diff;
   logic [AW:0]               slot_sum;
   logic [AW-1:0]             slot;
   logic [AW-1:0]             oldest_next;
   logic [BYTES_W-1:0]        bytes_less;

   // Descriptor ring; the read port always tracks the head entry
   btfifo_ram #(
      .WIDTH (RW),
      .DEPTH (ENTRY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (slot),
      .wr_data ({len_ff, ts_ff}),
      .rd_addr (oldest_in),
      .rd_data (rd_data)
   );

   assign head_len = rd_data[RW-1:STAMP_W];
   assign head_ts  = rd_data[STAMP_W-1:0];

   // Arithmetic shared by the checks and the updates
   assign bytes_sum   = {1'b0, bytes_ff} + (BYTES_W + 1)'(len_ff);
   assign diff        = {ts_ff[STAMP_W-1], ts_ff} - {head_ts[STAMP_W-1], head_ts};
   assign bytes_less  = (bytes_ff > BYTES_W'(head_len)) ? bytes_ff - BYTES_W'(head_len) : '0;
   assign oldest_next = (oldest_ff == AW'(ENTRY_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
   assign slot_sum    = (AW + 1)'(oldest_ff) + (AW + 1)'(entries_ff);
   assign slot        = (slot_sum >= (AW + 1)'(ENTRY_DEPTH))
                        ? AW'(slot_sum - (AW + 1)'(ENTRY_DEPTH)) : slot_sum[AW-1:0];

   // Status toward the controller
   always_comb begin
      sts.is_clear    = (op_ff == OP_CLEAR);
      sts.too_large   = (max_bytes_ff != '0) && (len_ff > max_bytes_ff);
      sts.empty       = (entries_ff == '0);
      sts.full        = (entries_ff == CW'(ENTRY_DEPTH));
      sts.byte_over   = (max_bytes_ff != '0) && !sts.empty
                        && (bytes_sum > (BYTES_W + 1)'(max_bytes_ff));
      sts.span_on     = (max_span_ff != '0);
      sts.ts_before   = diff[STAMP_W];
      sts.out_of_span = diff[STAMP_W] || (diff[STAMP_W-1:0] > STAMP_W'(max_span_ff));
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Ring state updates
   always_comb begin
      oldest_in  = oldest_ff;
      entries_in = entries_ff;
      bytes_in   = bytes_ff;
      evicted_in = evicted_ff;
      if (cmd.latch) begin
         evicted_in = '0;
      end
      if (cmd.do_clear) begin
         oldest_in  = '0;
         entries_in = '0;
         bytes_in   = '0;
         evicted_in = entries_ff;
      end else if (cmd.evict) begin
         oldest_in  = oldest_next;
         entries_in = entries_ff - 1'b1;
         bytes_in   = bytes_less;
         evicted_in = evicted_ff + 1'b1;
      end else if (cmd.append) begin
         entries_in = entries_ff + 1'b1;
         bytes_in   = bytes_sum[BYTES_W] ? BYTES_SAT : bytes_sum[BYTES_W-1:0];
      end
   end

   // Configuration writes
   always_comb begin
      max_bytes_in = max_bytes_ff;
      max_span_in  = max_span_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_BYTES: max_bytes_in = csr_wdata[LEN_W-1:0];
            CSR_MAX_SPAN:  max_span_in  = csr_wdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   // Result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         entries_ff   <= '0;
         bytes_ff     <= '0;
         max_bytes_ff <= MAX_BYTES_RESET;
         max_span_ff  <= MAX_SPAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff    <= oldest_in;
         entries_ff   <= entries_in;
         bytes_ff     <= bytes_in;
         max_bytes_ff <= max_bytes_in;
         max_span_ff  <= max_span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      evicted_ff <= evicted_in;
      if (cmd.latch) begin
         op_ff  <= req_data.operation;
         len_ff <= req_data.msg_length;
         ts_ff  <= req_data.timestamp;
      end
      if (cmd.status_we) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.evicted_count <= COUNT_W'(evicted_ff);
         rsp_ff.entry_count   <= COUNT_W'(entries_ff);
         rsp_ff.bytes_held    <= bytes_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/btfifo_ctrl.sv
// Controller: sequences clear, oversize check, byte eviction, time-window eviction and append per item.
// Depends on btfifo_pkg.
module btfifo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  btfifo_pkg::sts_type sts,
   output btfifo_pkg::cmd_type cmd
);
   import btfifo_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_BYTE   = 3'd1;
   localparam logic [2:0] S_TCHK   = 3'd2;
   localparam logic [2:0] S_TEVICT = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;
   logic       finish;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      finish    = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         // Hand off the last result and take the next beat
         S_IDLE: begin
            cmd.load_rsp = pend_ff && sts.out_free;
            req_ready    = !pend_ff || sts.out_free;
            if (req_valid && req_ready) begin
               cmd.latch = 1'b1;
               state_in  = S_BYTE;
            end
         end
         // Clear, oversize check, then evict until the length fits
         S_BYTE: begin
            if (sts.is_clear) begin
               cmd.do_clear  = 1'b1;
               cmd.status_we = 1'b1;
               cmd.status    = STATUS_CLEARED;
               finish        = 1'b1;
            end else if (sts.too_large) begin
               cmd.status_we = 1'b1;
               cmd.status    = STATUS_LARGE;
               finish        = 1'b1;
            end else if (sts.byte_over) begin
               cmd.evict = 1'b1;
            end else begin
               state_in = S_TCHK;
            end
         end
         // First look at the head timestamp
         S_TCHK: begin
            if (!sts.span_on || sts.empty) begin
               state_in = S_APPEND;
            end else if (sts.ts_before) begin
               cmd.status_we = 1'b1;
               cmd.status    = STATUS_EARLY;
               finish        = 1'b1;
            end else if (sts.out_of_span) begin
               cmd.evict = 1'b1;
               state_in  = S_TEVICT;
            end else begin
               state_in = S_APPEND;
            end
         end
         // Evict while the head is outside the window
         S_TEVICT: begin
            if (!sts.empty && sts.out_of_span) begin
               cmd.evict = 1'b1;
            end else begin
               state_in = S_APPEND;
            end
         end
         // Make room if full, then store
         S_APPEND: begin
            if (sts.full) begin
               cmd.evict = 1'b1;
            end else begin
               cmd.append    = 1'b1;
               cmd.status_we = 1'b1;
               cmd.status    = STATUS_STORED;
               finish        = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = S_IDLE;
      end
   end

   // Result pending until it moves into the output register
   always_comb begin
      pend_in = pend_ff;
      if (cmd.load_rsp) begin
         pend_in = 1'b0;
      end
      if (finish) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

### hw/rtl/byte_and_time_bounded_fifo_core.sv
// Top level of the byte- and time-bounded descriptor FIFO.
// Depends on btfifo_pkg, btfifo_ctrl, btfifo_dp and btfifo_ram.
//
// Keeps a ring of up to ENTRY_DEPTH message descriptors (length, signed
// timestamp) and a saturating byte total. Each request beat returns exactly
// one response beat. A clear or an oversized push is finished in the byte
// check state, a push dropped as earlier than the oldest entry in the time
// check state, and a stored push in the append state; every evicted entry
// takes a step of its own, since the descriptor RAM's single read port
// delivers one head entry per cycle. A finished result sits in an output
// register, so the next beat is taken while it waits. Configuration writes
// are taken at any time but are meant for idle periods.
module byte_and_time_bounded_fifo_core #(
   parameter int ENTRY_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  btfifo_pkg::req_type          req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output btfifo_pkg::rsp_type          rsp_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [btfifo_pkg::CSR_W-1:0] csr_wdata
);
   import btfifo_pkg::*;

   cmd_type cmd;
   sts_type sts;

   btfifo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   btfifo_dp #(
      .ENTRY_DEPTH (ENTRY_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Never store into a full ring
   a_append_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !sts.full)
      else $error("append issued while ring full");

   // Never evict from an empty ring
   a_evict_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> !sts.empty)
      else $error("evict issued while ring empty");

   // One ring update per cycle
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.evict, cmd.append, cmd.do_clear}))
      else $error("conflicting ring updates");

   // An oversized push removes nothing
   a_large_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_LARGE) |-> (rsp_data.evicted_count == '0))
      else $error("oversized push evicted entries");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_and_time_bounded_fifo_core: directed and random
// descriptor beats, checked against an in-bench ring predictor. Depends on btfifo_pkg.
module tb_top;
   import btfifo_pkg::*;

   localparam int DEPTH         = 256;
   localparam int RUN_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES = DEPTH + 50;
   localparam int REPORT_MAX    = 10;
   localparam int OUTCOME_SLOTS = 64;

   localparam logic signed [STAMP_W-1:0] TS_MIN   = 64'sh8000_0000_0000_0000;
   localparam logic signed [STAMP_W-1:0] TS_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic [SPAN_W-1:0]         SPAN_TOP = '1;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

   // DUT ports
   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic                 csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // Shadow copy of the ring and its registers
   logic [LEN_W-1:0]          shadow_len   [DEPTH];
   logic signed [STAMP_W-1:0] shadow_stamp [DEPTH];
   int unsigned               shadow_head;
   int unsigned               shadow_fill;
   logic [BYTES_W-1:0]        shadow_total;
   logic [LEN_W-1:0]          cfg_max_bytes;
   logic [SPAN_W-1:0]         cfg_max_span;

   // Expected outcomes, oldest first (circular, write and read counters)
   rsp_type outcome_fifo [OUTCOME_SLOTS];
   int      outcome_wr = 0;
   int      outcome_rd = 0;

   int                        send_idle_pct  = 0;
   int                        recv_stall_pct = 0;
   int                        rsp_hold_req   = 0;
   int                        fault_count    = 0;
   int                        beats_sent     = 0;
   int                        results_seen   = 0;
   int                        cycle_count    = 0;
   int                        status_tally [4];
   logic signed [STAMP_W-1:0] ts_cursor;

   byte_and_time_bounded_fifo_core #(.ENTRY_DEPTH(DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hang guard
   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // Pop the head entry; byte total floors at zero
   function automatic void drop_oldest();
      logic [BYTES_W-1:0] len;
      len          = {8'd0, shadow_len[shadow_head]};
      shadow_total = (shadow_total > len) ? shadow_total - len : '0;
      shadow_head  = (shadow_head + 1) % DEPTH;
      shadow_fill--;
   endfunction

   function automatic rsp_type predict_outcome(input req_type beat);
      rsp_type                   res;
      logic [63:0]               len;
      logic [63:0]               total;
      logic [63:0]               gap;
      logic signed [STAMP_W-1:0] ts;
      logic signed [STAMP_W-1:0] old;
      int unsigned               gone;
      int unsigned               slot;
      bit                        early;
      bit                        stale;
      len   = {32'd0, beat.msg_length};
      ts    = beat.timestamp;
      gone  = 0;
      early = 1'b0;
      res   = '0;
      if (beat.operation == OP_CLEAR) begin
         gone         = shadow_fill;
         shadow_fill  = 0;
         shadow_head  = 0;
         shadow_total = '0;
         res.status   = STATUS_CLEARED;
      end else if (cfg_max_bytes != 0 && beat.msg_length > cfg_max_bytes) begin
         res.status = STATUS_LARGE;
      end else begin
         // make room in the byte budget
         while (cfg_max_bytes != 0 && shadow_fill > 0 &&
                {24'd0, shadow_total} > {32'd0, cfg_max_bytes} - len) begin
            drop_oldest();
            gone++;
         end
         // time window against the head entry
         if (cfg_max_span != 0 && shadow_fill > 0) begin
            if (ts < shadow_stamp[shadow_head]) begin
               early = 1'b1;
            end else begin
               while (shadow_fill > 0) begin
                  old = shadow_stamp[shadow_head];
                  if (ts < old) begin
                     stale = 1'b1;
                  end else begin
                     gap   = ts - old;
                     stale = gap > {16'd0, cfg_max_span};
                  end
                  if (!stale) break;
                  drop_oldest();
                  gone++;
               end
            end
         end
         if (early) begin
            res.status = STATUS_EARLY;
         end else begin
            if (shadow_fill >= DEPTH) begin
               drop_oldest();
               gone++;
            end
            slot               = (shadow_head + shadow_fill) % DEPTH;
            shadow_len[slot]   = beat.msg_length;
            shadow_stamp[slot] = ts;
            shadow_fill++;
            total = {24'd0, shadow_total};
            if (total > {24'd0, BYTES_SAT} - len) shadow_total = BYTES_SAT;
            else shadow_total = shadow_total + len[BYTES_W-1:0];
            res.status = STATUS_STORED;
         end
      end
      res.evicted_count = gone[COUNT_W-1:0];
      res.entry_count   = shadow_fill[COUNT_W-1:0];
      res.bytes_held    = shadow_total;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   task automatic set_idle_mode(input idle_mode_e mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SEND: begin
            send_idle_pct  = 46;
            recv_stall_pct = 0;
         end
         IDLE_RECV: begin
            send_idle_pct  = 0;
            recv_stall_pct = 46;
         end
         default: begin
            send_idle_pct  = 35;
            recv_stall_pct = 35;
         end
      endcase
   endtask

   // Offer one request beat, hold it until taken, then record its outcome
   task automatic send_beat(input req_type beat);
      rsp_type outcome;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outcome = predict_outcome(beat);
      outcome_fifo[outcome_wr % OUTCOME_SLOTS] = outcome;
      outcome_wr++;
      status_tally[outcome.status]++;
      beats_sent++;
   endtask

   task automatic push_desc(input logic [LEN_W-1:0] len, input logic signed [STAMP_W-1:0] ts);
      req_type beat;
      beat.operation  = OP_PUSH;
      beat.msg_length = len;
      beat.timestamp  = ts;
      send_beat(beat);
   endtask

   // Payload fields of a clear carry noise
   task automatic clear_ring();
      req_type beat;
      beat.operation  = OP_CLEAR;
      beat.msg_length = $urandom;
      beat.timestamp  = {$urandom, $urandom};
      send_beat(beat);
   endtask

   // Stop offering and wait until every outcome has been checked
   task automatic drain_results();
      req_valid <= 1'b0;
      while (outcome_wr != outcome_rd) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MAX_BYTES) cfg_max_bytes = value[LEN_W-1:0];
      else cfg_max_span = value[SPAN_W-1:0];
      @(posedge clock);
   endtask

   // Both limits are rewritten with the block idle; spare upper bits carry noise
   task automatic set_limits(input logic [LEN_W-1:0]  bytes_cap,
                             input logic [SPAN_W-1:0] span_cap);
      logic [CSR_W-LEN_W-1:0] junk;
      junk = (CSR_W - LEN_W)'($urandom);
      drain_results();
      write_csr(CSR_MAX_BYTES, {junk, bytes_cap});
      write_csr(CSR_MAX_SPAN, span_cap);
   endtask

   function automatic req_type make_random_beat();
      req_type     beat;
      int unsigned pick;
      logic [31:0] reach;
      logic [31:0] budget;
      pick   = $urandom_range(99);
      budget = cfg_max_bytes;
      reach  = (cfg_max_span == 0) ? 32'd1000 :
               (cfg_max_span > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : cfg_max_span[31:0];
      beat.operation = OP_PUSH;
      if (budget == 0)
         beat.msg_length = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096);
      else
         beat.msg_length = $urandom_range((budget > 16) ? budget / 4 : budget);
      beat.timestamp = ts_cursor;
      if (pick < 5) begin
         beat.operation  = OP_CLEAR;
         beat.msg_length = $urandom;
         beat.timestamp  = {$urandom, $urandom};
      end else if (pick < 80) begin
         // in-order arrival inside or just past the window
         ts_cursor      = ts_cursor + $urandom_range(reach / 2 + 1);
         beat.timestamp = ts_cursor;
      end else if (pick < 88) begin
         // arrives out of order
         beat.timestamp = ts_cursor - $urandom_range(reach) - 1;
      end else if (pick < 94 && budget != 0 && budget != '1) begin
         beat.msg_length = $urandom_range(budget + 1, 32'hFFFF_FFFF);
      end else begin
         beat.msg_length = $urandom;
         case ($urandom_range(3))
            0:       beat.timestamp = TS_MIN;
            1:       beat.timestamp = TS_MAX;
            default: beat.timestamp = {$urandom, $urandom};
         endcase
      end
      return beat;
   endfunction

   // ---------------------------------------------------------------
   // Result side: stall pattern and checking
   // ---------------------------------------------------------------

   task automatic report_fault(input string what, input rsp_type want, input rsp_type got);
      fault_count++;
      if (fault_count <= REPORT_MAX)
         $display("[%0t] %s: exp st %0d ev %0d cnt %0d bytes %0h, got st %0d ev %0d cnt %0d %0h",
                  $time, what, want.status, want.evicted_count, want.entry_count,
                  want.bytes_held, got.status, got.evicted_count, got.entry_count,
                  got.bytes_held);
   endtask

   initial begin : result_checker
      rsp_type want;
      int      hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            results_seen++;
            if (outcome_wr == outcome_rd) begin
               report_fault("unexpected result beat", '0, rsp_data);
            end else begin
               want = outcome_fifo[outcome_rd % OUTCOME_SLOTS];
               outcome_rd++;
               if (rsp_data.status !== want.status ||
                   rsp_data.evicted_count !== want.evicted_count ||
                   rsp_data.entry_count !== want.entry_count ||
                   rsp_data.bytes_held !== want.bytes_held)
                  report_fault("result mismatch", want, rsp_data);
            end
         end
         // long hold-off, counted here
         if (rsp_hold_req != 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Byte budget edges at the reset settings, then with no budget
   task automatic test_budget_edges();
      set_idle_mode(IDLE_NONE);
      push_desc(32'd0, 64'sd0);
      push_desc(32'hFFFF_FFFF, 64'sd0);
      push_desc(MAX_BYTES_RESET + 32'd1, 64'sd5);
      push_desc(MAX_BYTES_RESET, TS_MAX);
      push_desc(32'd1, TS_MIN);
      clear_ring();
      clear_ring();
      set_limits('0, '0);
      push_desc(32'hFFFF_FFFF, TS_MAX);
      push_desc(32'hFFFF_FFFF, TS_MIN);
      clear_ring();
   endtask

   // Span window: boundary, early drop, newer entry ahead of the push, extremes
   task automatic test_span_window();
      set_idle_mode(IDLE_NONE);
      set_limits(32'hFFFF_FFFF, 48'd100);
      push_desc(32'd5, 64'sd1000);
      push_desc(32'd5, 64'sd1050);
      push_desc(32'd5, 64'sd1200);
      push_desc(32'd5, 64'sd500);
      push_desc(32'd5, 64'sd1200);
      push_desc(32'd5, 64'sd1300);
      push_desc(32'd5, 64'sd1301);
      clear_ring();
      // store out of order with the window off, then turn it on
      set_limits(32'hFFFF_FFFF, '0);
      push_desc(32'd1, 64'sd0);
      push_desc(32'd1, 64'sd1000);
      push_desc(32'd1, 64'sd200);
      set_limits(32'hFFFF_FFFF, 48'd100);
      push_desc(32'd1, 64'sd500);
      set_limits(32'hFFFF_FFFF, SPAN_TOP);
      clear_ring();
      push_desc(32'd7, TS_MIN);
      push_desc(32'd7, TS_MAX);
      push_desc(32'd7, TS_MIN);
   endtask

   // Fill past the depth, clear a full ring, then evict a full ring by budget
   task automatic test_ring_wrap();
      int n;
      set_idle_mode(IDLE_NONE);
      set_limits('0, '0);
      clear_ring();
      for (n = 0; n < DEPTH + 20; n++) begin
         ts_cursor = ts_cursor + $urandom_range(1000, 1);
         push_desc($urandom, ts_cursor);
      end
      clear_ring();
      set_limits(DEPTH, '0);
      for (n = 0; n <= DEPTH; n++) begin
         ts_cursor = ts_cursor + $urandom_range(1000, 1);
         push_desc(32'd1, ts_cursor);
      end
      push_desc(DEPTH, ts_cursor);
      clear_ring();
   endtask

   // Receiver holds off while the sender keeps offering; then sender waits it out
   task automatic test_output_stall();
      int n;
      set_idle_mode(IDLE_NONE);
      set_limits(32'd4096, 48'd2000);
      clear_ring();
      rsp_hold_req = 400;
      for (n = 0; n < 40; n++) begin
         ts_cursor = ts_cursor + $urandom_range(600);
         push_desc($urandom_range(600, 1), ts_cursor);
      end
      drain_results();
   endtask

   // Random traffic over several register settings and every idle pattern
   task automatic test_random_mix();
      int          seg;
      int          n;
      logic [63:0] wide;
      for (seg = 0; seg < 8; seg++) begin
         wide = {$urandom, $urandom};
         case (seg)
            0:       set_limits('0, '0);
            1:       set_limits($urandom_range(20000, 2000),
                                SPAN_W'($urandom_range(5000, 100)));
            2:       set_limits(32'd1, 48'd1);
            3:       set_limits(32'hFFFF_FFFF, SPAN_TOP);
            4:       set_limits($urandom_range(3000, 500), '0);
            5:       set_limits('0, SPAN_W'($urandom_range(1000, 1)));
            6:       set_limits($urandom, wide[SPAN_W-1:0]);
            default: set_limits(MAX_BYTES_RESET, MAX_SPAN_RESET);
         endcase
         set_idle_mode(idle_mode_e'(seg % 4));
         ts_cursor = {$urandom, $urandom};
         clear_ring();
         for (n = 0; n < 25; n++) send_beat(make_random_beat());
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin : main_sequence
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_MAX_BYTES;
      csr_wdata     = '0;
      shadow_head   = 0;
      shadow_fill   = 0;
      shadow_total  = '0;
      cfg_max_bytes = MAX_BYTES_RESET;
      cfg_max_span  = MAX_SPAN_RESET;
      ts_cursor     = '0;
      status_tally  = '{default: 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_budget_edges();
      test_span_window();
      test_ring_wrap();
      test_output_stall();
      test_random_mix();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d request beats (%0d stored, %0d too large, %0d early, %0d clears)",
               beats_sent, status_tally[STATUS_STORED], status_tally[STATUS_LARGE],
               status_tally[STATUS_EARLY], status_tally[STATUS_CLEARED]);
      $display("Summary: %0d results checked, %0d faults, %0d cycles, limits and idle swept",
               results_seen, fault_count, cycle_count);
      if (fault_count == 0 && outcome_wr == outcome_rd) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
